// ===== design/tec_pkg.sv =====
// Package for the throttle expo curve block: field widths, register codes,
// reset values, reciprocal constants and the divider pipeline payload type.
// No dependencies.
`default_nettype none

package tec_pkg;

	localparam int TABLE_LENGTH_DEF = 12;

	// port fields
	localparam int IDX_W  = 4;
	localparam int MID_W  = 7;
	localparam int EXPO_W = 7;
	localparam int THR_W  = 12;
	localparam int OUT_W  = 17;
	localparam int CFG_W  = 12;

	// internal datapath widths
	localparam int TENS_W  = 8;   // 10*index, at most 150
	localparam int D_W     = 9;   // signed distance from the midpoint
	localparam int AD_W    = 8;   // |d|
	localparam int AY_W    = 7;   // |y|
	localparam int SQ_W    = 14;  // y*y
	localparam int DD_W    = 15;  // d*d
	localparam int NUM_W   = 22;  // expo*d*d, also the quotient width
	localparam int BR_W    = 23;  // signed bracket term
	localparam int PROD_W  = 30;  // signed d*bracket
	localparam int MAG10_W = 29;
	localparam int RCP_W   = 29;
	localparam int SHIFT10 = 32;
	localparam int Q10_W   = MAG10_W + RCP_W - SHIFT10;
	localparam int VSUM_W  = 28;
	localparam int V_W     = 16;
	localparam int M10_W   = 11;  // 10*mid_point
	localparam int DIFF_W  = 13;
	localparam int P_W     = DIFF_W + V_W;
	localparam int MAG1K_W = 28;
	localparam int SHIFT1K = 38;
	localparam int Q1K_W   = MAG1K_W + RCP_W - SHIFT1K;
	localparam int RES_W   = 21;

	// ceil(2^32/10) and ceil(2^38/1000): exact quotients over the magnitudes seen here
	localparam logic [RCP_W-1:0] RECIP10 = 29'd429496730;
	localparam logic [RCP_W-1:0] RECIP1K = 29'd274877907;

	localparam logic [MID_W-1:0] PCT_FULL = 7'd100;

	localparam logic signed [V_W-1:0]   V_MAX   = 16'sh7FFF;
	localparam logic signed [V_W-1:0]   V_MIN   = 16'sh8000;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;

	localparam logic [MID_W-1:0]  MID_RST  = 7'd50;
	localparam logic [EXPO_W-1:0] EXPO_RST = 7'd0;
	localparam logic [THR_W-1:0]  TMIN_RST = 12'd1150;
	localparam logic [THR_W-1:0]  TMAX_RST = 12'd1850;

	typedef enum logic [1:0] {
		CFG_MID_POINT    = 2'd0,
		CFG_EXPO_AMOUNT  = 2'd1,
		CFG_THROTTLE_MIN = 2'd2,
		CFG_THROTTLE_MAX = 2'd3
	} cfg_reg_t;

	// one item in flight through the divider chain
	typedef struct packed {
		logic [SQ_W-1:0]        rem;  // partial remainder
		logic [NUM_W-1:0]       dq;   // dividend bits out at the top, quotient bits in below
		logic [SQ_W-1:0]        dvs;  // divisor y*y
		logic signed [D_W-1:0]  dlt;  // d, carried for the back end
	} tec_div_t;

endpackage

`default_nettype wire

// ===== design/throttle_expo_curve.sv =====
// Throttle expo curve: one curve point per table index.
// Depends on tec_pkg and tec_div_chain.
//
// Input channel: point_index with in_valid/in_ready. Output channel:
// curve_value (signed) with out_valid/out_ready. Configuration: write
// cfg_data to register cfg_index while cfg_wen is high (mid point, expo
// amount, throttle min, throttle max); write only while no item is in flight.
//
// Throughput is one item per cycle while out_ready stays high. From acceptance
// to out_valid an item passes three front stages, a 22-cell division chain that settles
// one quotient bit of expo*d*d/(y*y) per cell, and seven back stages that
// scale by the bracket, divide by 10 and 1000 through reciprocal
// multipliers, and saturate.
//
// Every stage has its own valid bit and loads when it is empty or when its
// successor loads, so bubbles collapse and input keeps flowing while a
// result waits in the output register. When out_ready stays low the
// pipeline fills and then in_ready drops. Reset empties every stage and
// restores the register defaults.
`default_nettype none

module throttle_expo_curve #(
	parameter int TABLE_LENGTH = tec_pkg::TABLE_LENGTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tec_pkg::IDX_W-1:0]      point_index,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [tec_pkg::OUT_W-1:0]    curve_value,
	input  wire logic                           cfg_wen,
	input  wire tec_pkg::cfg_reg_t              cfg_index,
	input  wire logic [tec_pkg::CFG_W-1:0]      cfg_data
);
	import tec_pkg::*;

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_LENGTH - 1);

	// configuration registers
	logic [MID_W-1:0]  mid_q;
	logic [EXPO_W-1:0] expo_q;
	logic [THR_W-1:0]  tmin_q;
	logic [THR_W-1:0]  tmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q  <= MID_RST;
			expo_q <= EXPO_RST;
			tmin_q <= TMIN_RST;
			tmax_q <= TMAX_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_MID_POINT:    mid_q  <= cfg_data[MID_W-1:0];
				CFG_EXPO_AMOUNT:  expo_q <= cfg_data[EXPO_W-1:0];
				CFG_THROTTLE_MIN: tmin_q <= cfg_data[THR_W-1:0];
				CFG_THROTTLE_MAX: tmax_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake of every stage
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9, rdy_s10;
	logic chain_up_ready, chain_dn_valid;
	tec_div_t chain_dn_data;

	assign rdy_s10 = !vld_s10 || out_ready;
	assign rdy_s9  = !vld_s9  || rdy_s10;
	assign rdy_s8  = !vld_s8  || rdy_s9;
	assign rdy_s7  = !vld_s7  || rdy_s8;
	assign rdy_s6  = !vld_s6  || rdy_s7;
	assign rdy_s5  = !vld_s5  || rdy_s6;
	assign rdy_s4  = !vld_s4  || rdy_s5;
	assign rdy_s3  = !vld_s3  || chain_up_ready;
	assign rdy_s2  = !vld_s2  || rdy_s3;
	assign rdy_s1  = !vld_s1  || rdy_s2;

	assign in_ready  = rdy_s1;
	assign out_valid = vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1  <= in_valid;
			if (rdy_s2)  vld_s2  <= vld_s1;
			if (rdy_s3)  vld_s3  <= vld_s2;
			if (rdy_s4)  vld_s4  <= chain_dn_valid;
			if (rdy_s5)  vld_s5  <= vld_s4;
			if (rdy_s6)  vld_s6  <= vld_s5;
			if (rdy_s7)  vld_s7  <= vld_s6;
			if (rdy_s8)  vld_s8  <= vld_s7;
			if (rdy_s9)  vld_s9  <= vld_s8;
			if (rdy_s10) vld_s10 <= vld_s9;
		end
	end

	// stage 1: saturate index, distance from midpoint, divisor base
	logic [IDX_W-1:0]        idx_c;
	logic [TENS_W-1:0]       tens_c;
	logic signed [D_W-1:0]   d_c;
	logic [AD_W-1:0]         ad_c;
	logic [AY_W-1:0]         ay_c;
	logic signed [D_W-1:0]   d_s1;
	logic [AD_W-1:0]         ad_s1;
	logic [AY_W-1:0]         ay_s1;

	always_comb begin
		idx_c  = (point_index > IDX_MAX) ? IDX_MAX : point_index;
		tens_c = {1'b0, idx_c, 3'b000} + {3'b000, idx_c, 1'b0};
		d_c    = $signed({1'b0, tens_c}) - $signed({2'b00, mid_q});
		ad_c   = d_c[D_W-1] ? AD_W'(-d_c) : d_c[AD_W-1:0];
		ay_c   = AY_W'(1);
		if (d_c[D_W-1]) begin
			ay_c = mid_q;
		end else if (d_c != '0) begin
			// 100 - mid, only its magnitude matters once squared
			if (mid_q <= PCT_FULL) begin
				ay_c = PCT_FULL - mid_q;
			end else begin
				ay_c = mid_q - PCT_FULL;
			end
		end
		// mid point at the far end would give a zero divisor: use one
		if (ay_c == '0) begin
			ay_c = AY_W'(1);
		end
	end

	// stage 2: squares
	logic [2*AY_W-1:0]       sq_full;
	logic [2*AD_W-1:0]       dd_full;
	logic [SQ_W-1:0]         sq_s2;
	logic [DD_W-1:0]         dd_s2;
	logic signed [D_W-1:0]   d_s2;

	assign sq_full = ay_s1 * ay_s1;
	assign dd_full = ad_s1 * ad_s1;

	// stage 3: dividend expo*d*d, enter the division chain
	logic [EXPO_W+DD_W-1:0]  num_full;
	tec_div_t                div_s3;

	assign num_full = expo_q * dd_s2;

	tec_div_chain u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s3),
		.up_ready (chain_up_ready),
		.up_data  (div_s3),
		.dn_valid (chain_dn_valid),
		.dn_ready (rdy_s4),
		.dn_data  (chain_dn_data)
	);

	// stage 4: bracket = 100 - expo + quotient
	logic signed [BR_W-1:0]  bracket_s4;
	logic signed [D_W-1:0]   d_s4;

	// stage 5: d * bracket
	logic signed [D_W+BR_W-1:0] prod_full;
	logic signed [PROD_W-1:0]   prod_s5;

	assign prod_full = d_s4 * bracket_s4;

	// stage 6: magnitude divided by 10
	logic [PROD_W-1:0]          mag10_c;
	logic [MAG10_W+RCP_W-1:0]   m10_full;
	logic [Q10_W-1:0]           q10_s6;
	logic                       neg_s6;

	assign mag10_c  = prod_s5[PROD_W-1] ? PROD_W'(-prod_s5) : PROD_W'(prod_s5);
	assign m10_full = mag10_c[MAG10_W-1:0] * RECIP10;

	// stage 7: restore sign, add 10*mid, saturate
	logic signed [VSUM_W-1:0]   q10_ext;
	logic signed [VSUM_W-1:0]   q10_sgn;
	logic signed [VSUM_W-1:0]   vsum_c;
	logic [M10_W-1:0]           mid10_c;
	logic signed [V_W-1:0]      v_c;
	logic signed [V_W-1:0]      v_s7;

	always_comb begin
		q10_ext = $signed(VSUM_W'(q10_s6));
		q10_sgn = neg_s6 ? -q10_ext : q10_ext;
		mid10_c = {1'b0, mid_q, 3'b000} + {3'b000, mid_q, 1'b0};
		vsum_c  = q10_sgn + $signed(VSUM_W'(mid10_c));
		if (vsum_c > V_MAX) begin
			v_c = V_MAX;
		end else if (vsum_c < V_MIN) begin
			v_c = V_MIN;
		end else begin
			v_c = vsum_c[V_W-1:0];
		end
	end

	// stage 8: (max - min) * v
	logic signed [DIFF_W-1:0]   diff_c;
	logic signed [P_W-1:0]      p_full;
	logic signed [P_W-1:0]      p_s8;

	assign diff_c = $signed({1'b0, tmax_q}) - $signed({1'b0, tmin_q});
	assign p_full = diff_c * v_s7;

	// stage 9: magnitude divided by 1000
	logic [P_W-1:0]             mag1k_c;
	logic [MAG1K_W+RCP_W-1:0]   m1k_full;
	logic [Q1K_W-1:0]           q1k_s9;
	logic                       neg_s9;

	assign mag1k_c  = p_s8[P_W-1] ? P_W'(-p_s8) : P_W'(p_s8);
	assign m1k_full = mag1k_c[MAG1K_W-1:0] * RECIP1K;

	// stage 10: restore sign, add min, saturate into the output register
	logic signed [RES_W-1:0]    q1k_ext;
	logic signed [RES_W-1:0]    q1k_sgn;
	logic signed [RES_W-1:0]    res_c;
	logic signed [OUT_W-1:0]    out_c;
	logic signed [OUT_W-1:0]    curve_value_s10;

	always_comb begin
		q1k_ext = $signed(RES_W'(q1k_s9));
		q1k_sgn = neg_s9 ? -q1k_ext : q1k_ext;
		res_c   = q1k_sgn + $signed(RES_W'(tmin_q));
		if (res_c > OUT_MAX) begin
			out_c = OUT_MAX;
		end else if (res_c < OUT_MIN) begin
			out_c = OUT_MIN;
		end else begin
			out_c = res_c[OUT_W-1:0];
		end
	end

	assign curve_value = curve_value_s10;

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d_s1  <= d_c;
			ad_s1 <= ad_c;
			ay_s1 <= ay_c;
		end
		if (rdy_s2) begin
			sq_s2 <= sq_full[SQ_W-1:0];
			dd_s2 <= dd_full[DD_W-1:0];
			d_s2  <= d_s1;
		end
		if (rdy_s3) begin
			div_s3.rem <= '0;
			div_s3.dq  <= num_full[NUM_W-1:0];
			div_s3.dvs <= sq_s2;
			div_s3.dlt <= d_s2;
		end
		if (rdy_s4) begin
			bracket_s4 <= BR_W'(chain_dn_data.dq) + BR_W'(PCT_FULL) - BR_W'(expo_q);
			d_s4       <= chain_dn_data.dlt;
		end
		if (rdy_s5) begin
			prod_s5 <= prod_full[PROD_W-1:0];
		end
		if (rdy_s6) begin
			q10_s6 <= m10_full[MAG10_W+RCP_W-1:SHIFT10];
			neg_s6 <= prod_s5[PROD_W-1];
		end
		if (rdy_s7) begin
			v_s7 <= v_c;
		end
		if (rdy_s8) begin
			p_s8 <= p_full;
		end
		if (rdy_s9) begin
			q1k_s9 <= m1k_full[MAG1K_W+RCP_W-1:SHIFT1K];
			neg_s9 <= p_s8[P_W-1];
		end
		if (rdy_s10) begin
			curve_value_s10 <= out_c;
		end
	end

	a_sq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> sq_s2 != '0)
		else $error("divisor square is zero");

	a_bracket_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !rdy_s5 |=> vld_s4 && $stable(bracket_s4))
		else $error("stalled bracket term lost or changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 && !out_ready |=> vld_s10 && $stable(curve_value_s10))
		else $error("stalled result lost or changed");

endmodule

`default_nettype wire

// ===== design/tec_div_cell.sv =====
// One restoring division cell: settles one quotient bit per item and
// passes the item to the next cell. Depends on tec_pkg.
`default_nettype none

module tec_div_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	output logic                  up_ready,
	input  wire tec_pkg::tec_div_t up_data,
	output logic                  dn_valid,
	input  wire logic             dn_ready,
	output tec_pkg::tec_div_t     dn_data
);
	import tec_pkg::*;

	logic              vld_q;
	tec_div_t          dat_q;
	tec_div_t          nxt;
	logic [SQ_W:0]     trial;
	logic              ge;

	assign up_ready = !vld_q || dn_ready;
	assign dn_valid = vld_q;
	assign dn_data  = dat_q;

	always_comb begin
		trial = {up_data.rem, up_data.dq[NUM_W-1]};
		ge    = trial >= {1'b0, up_data.dvs};
		nxt   = up_data;
		nxt.rem = ge ? SQ_W'(trial - {1'b0, up_data.dvs}) : trial[SQ_W-1:0];
		nxt.dq  = {up_data.dq[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			dat_q <= nxt;
		end
	end

	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> dat_q.rem < dat_q.dvs)
		else $error("partial remainder not below divisor");

	a_dvs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> dat_q.dvs != '0)
		else $error("zero divisor in division chain");

	a_cell_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !dn_ready |=> vld_q && $stable(dat_q))
		else $error("stalled item lost or changed in division cell");

endmodule

`default_nettype wire

// ===== design/tec_div_chain.sv =====
// Row of division cells, one quotient bit per cell, one item per cycle while dn_ready holds.
// Depends on tec_pkg and tec_div_cell.
`default_nettype none

module tec_div_chain (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	output logic                  up_ready,
	input  wire tec_pkg::tec_div_t up_data,
	output logic                  dn_valid,
	input  wire logic             dn_ready,
	output tec_pkg::tec_div_t     dn_data
);
	import tec_pkg::*;

	logic     vld [0:NUM_W];
	logic     rdy [0:NUM_W];
	tec_div_t dat [0:NUM_W];

	assign vld[0]     = up_valid;
	assign dat[0]     = up_data;
	assign up_ready   = rdy[0];
	assign dn_valid   = vld[NUM_W];
	assign dn_data    = dat[NUM_W];
	assign rdy[NUM_W] = dn_ready;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		tec_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_data  (dat[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_data  (dat[i+1])
		);
	end

endmodule

`default_nettype wire

// ===== tb/sv/throttle_expo_curve_test.sv =====
// Self-checking bench for throttle_expo_curve: drives table indexes under
// several curve settings and compares every curve_value with a local model.
// Depends on tec_pkg and the throttle_expo_curve RTL.
`default_nettype none

module throttle_expo_curve_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tec_pkg::*;

	localparam int TBL_LAST   = TABLE_LENGTH_DEF - 1;
	localparam int ITEM_COUNT = 1900;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		logic [IDX_W-1:0]        ix;
		logic signed [OUT_W-1:0] val;
	} curve_point_t;

	class curve_ledger;
		logic [MID_W-1:0]  mid;
		logic [EXPO_W-1:0] expo;
		logic [THR_W-1:0]  tmin;
		logic [THR_W-1:0]  tmax;
		curve_point_t      awaited[$];
		int                failures;

		function new();
			mid      = MID_RST;
			expo     = EXPO_RST;
			tmin     = TMIN_RST;
			tmax     = TMAX_RST;
			failures = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
			case (r)
				CFG_MID_POINT:    mid  = v[MID_W-1:0];
				CFG_EXPO_AMOUNT:  expo = v[EXPO_W-1:0];
				CFG_THROTTLE_MIN: tmin = v[THR_W-1:0];
				CFG_THROTTLE_MAX: tmax = v[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [OUT_W-1:0] curve_point(logic [IDX_W-1:0] ix);
			longint idx, m, e, d, y, sq, br, v, res;
			idx = ix;
			m   = mid;
			e   = expo;
			if (idx > TBL_LAST)
				idx = TBL_LAST;
			d = 10 * idx - m;
			y = 1;
			if (d > 0)
				y = 100 - m;
			if (d < 0)
				y = m;
			sq = y * y;
			// flat end of the curve: avoid the zero divisor
			if (sq == 0)
				sq = 1;
			br = 100 - e + (e * d * d) / sq;
			v  = 10 * m + (d * br) / 10;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			res = longint'(tmin) + ((longint'(tmax) - longint'(tmin)) * v) / 1000;
			if (res > 65535)
				res = 65535;
			if (res < -65536)
				res = -65536;
			return res[OUT_W-1:0];
		endfunction

		function void note_index(logic [IDX_W-1:0] ix);
			curve_point_t p;
			p.ix  = ix;
			p.val = curve_point(ix);
			awaited.push_back(p);
		endfunction

		function void check_point(logic signed [OUT_W-1:0] got);
			curve_point_t p;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: curve_value %0d arrived with no item pending", $time, got);
				return;
			end
			p = awaited.pop_front();
			if (got !== p.val) begin
				failures++;
				if (failures <= 10)
					$display("%0t: index %0d mid %0d expo %0d min %0d max %0d: expected %0d, got %0d",
						$time, p.ix, mid, expo, tmin, tmax, p.val, got);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [IDX_W-1:0]        point_index = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [OUT_W-1:0] curve_value;
	logic                    cfg_wen = 1'b0;
	cfg_reg_t                cfg_index = CFG_MID_POINT;
	logic [CFG_W-1:0]        cfg_data = '0;

	bit snd_gaps = 1'b1;
	bit rcv_gaps = 1'b1;

	curve_ledger ledger = new();

	throttle_expo_curve DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_index (point_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.curve_value (curve_value),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				ledger.note_index(point_index);
			if (out_valid && out_ready)
				ledger.check_point(curve_value);
		end
	end

	// called at a clock edge; returns at the edge that accepts the item
	task automatic send_index(input logic [IDX_W-1:0] ix);
		int gap;
		gap = snd_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		point_index <= ix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drop valid and hold until every issued item has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic program_curve(input logic [CFG_W-1:0] m, e, lo, hi);
		cfg_reg_t         regs[4];
		logic [CFG_W-1:0] vals[4];
		regs = '{CFG_MID_POINT, CFG_EXPO_AMOUNT, CFG_THROTTLE_MIN, CFG_THROTTLE_MAX};
		vals = '{m, e, lo, hi};
		for (int r = 0; r < 4; r++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= regs[r];
			cfg_data  <= vals[r];
			@(posedge clk);
			ledger.set_reg(regs[r], vals[r]);
		end
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_pct();
		logic [CFG_W-MID_W-1:0] junk;
		logic [MID_W-1:0]       pct;
		junk = ($urandom_range(0, 3) == 0) ? (CFG_W-MID_W)'($urandom_range(0, 31)) : '0;
		case ($urandom_range(0, 9))
			0: pct = 7'd0;
			1: pct = 7'd100;
			2: pct = 7'd127;
			3: pct = 7'($urandom_range(101, 127));
			default: pct = 7'($urandom_range(0, 100));
		endcase
		return {junk, pct};
	endfunction

	function automatic logic [CFG_W-1:0] pick_thr();
		case ($urandom_range(0, 7))
			0: return 12'd0;
			1: return 12'd4095;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = rcv_gaps ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int sent;
		int n;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, every index including those past the table end
		for (int i = 0; i < 16; i++)
			send_index(IDX_W'(i));
		drain();

		// flat top at mid 100, inverted output range, heavy expo
		program_curve(12'd100, 12'd127, 12'd4095, 12'd0);
		send_index(4'd0);
		send_index(4'd10);
		send_index(4'd11);
		send_index(4'd15);
		drain();

		// flat bottom at mid 0, full output range
		program_curve(12'd0, 12'd100, 12'd0, 12'd4095);
		send_index(4'd0);
		send_index(4'd11);
		drain();

		// midpoint beyond 100
		program_curve(12'd127, 12'd127, 12'd0, 12'd4095);
		send_index(4'd0);
		send_index(4'd11);
		send_index(4'd15);
		drain();

		while (sent < ITEM_COUNT) begin
			snd_gaps = ($urandom_range(0, 3) != 0);
			rcv_gaps = ($urandom_range(0, 3) != 0);
			program_curve(pick_pct(), pick_pct(), pick_thr(), pick_thr());
			n = $urandom_range(20, 120);
			repeat (n) begin
				send_index(IDX_W'($urandom_range(0, 15)));
				sent++;
			end
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (ledger.failures == 0 && ledger.pending() == 0)
			$display("throttle_expo_curve_test OK");
		else
			$display("throttle_expo_curve_test NOT OK");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("throttle_expo_curve_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
